@@ hw/rtl/clt_pkg.sv @@
// Package for the configuration line tokenizer: token modes, result kinds and
// the character codes the lexer recognizes. No dependencies.
package clt_pkg;

  typedef enum logic [3:0] {
    MODE_IDLE    = 4'b0001,
    MODE_WORD    = 4'b0010,
    MODE_QUOTE   = 4'b0100,
    MODE_COMMENT = 4'b1000
  } mode_t;

  typedef enum logic [2:0] {
    KIND_BYTE     = 3'd0,
    KIND_WORD     = 3'd1,
    KIND_NUMBER   = 3'd2,
    KIND_GENERIC  = 3'd3,
    KIND_COMMENT  = 3'd4,
    KIND_NEWLINE  = 3'd5,
    KIND_END      = 3'd6,
    KIND_BADQUOTE = 3'd7
  } kind_t;

  localparam int unsigned GEN_W      = 8;
  localparam int unsigned CFG_ADDR_W = 3;
  localparam int unsigned CFG_DATA_W = 32;

  // Register index, taken from the word address bit of the configuration port.
  localparam logic REG_GENERIC_VALUE = 1'b0;

  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_VT     = 8'h0B;
  localparam logic [7:0] CH_FF     = 8'h0C;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;

  function automatic logic is_blank(input logic [7:0] c);
    return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_CR) || (c == CH_VT) ||
           (c == CH_FF);
  endfunction

endpackage

@@ hw/rtl/config_line_tokenizer.sv @@
// Top level of the configuration line tokenizer: input register, lexer step,
// result queue and the configuration register. Uses clt_pkg, clt_lexer and
// clt_result_fifo.
//
//   Channel   Direction  Handshake             Payload
//   in_       input      in_valid / in_ready   in_char_byte, in_end_of_input
//   out_      output     out_valid / out_ready kind, text, number, position, length, last
//   APB       input      psel/penable/pready   generic_value at byte address 0
//
// An accepted byte is held in the input register while the lexer step works on
// it; its results are written to the result queue once the queue has room for
// both, and out_valid is driven from that queue.
// One item is taken per cycle while the result queue has room for two results;
// an item that yields two results costs two output transactions, so the
// sustained rate is one result per cycle on the output side while out_ready is high.
// Reset is synchronous; no clearing pass is needed after it.
module config_line_tokenizer #(
  parameter int POS_WIDTH = 16,
  parameter int NUM_WIDTH = 31
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [7:0]                     in_char_byte,
  input  logic                           in_end_of_input,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [2:0]                     out_kind,
  output logic [7:0]                     out_text_byte,
  output logic [NUM_WIDTH-1:0]           out_number_value,
  output logic [POS_WIDTH-1:0]           out_start_line,
  output logic [POS_WIDTH-1:0]           out_start_column,
  output logic [POS_WIDTH-1:0]           out_token_length,
  output logic                           out_last,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [clt_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [clt_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [clt_pkg::CFG_DATA_W-1:0] prdata,
  output logic                           pready
);

  import clt_pkg::*;

  localparam int RES_W      = 12 + NUM_WIDTH + 3 * POS_WIDTH;
  localparam int FIFO_DEPTH = 4;

  logic             stg_valid_r, stg_valid_nxt;
  logic [7:0]       stg_byte_r;
  logic             stg_eoi_r;
  logic             advance;
  logic             room2;
  logic [1:0]       res_cnt, push_cnt;
  logic [RES_W-1:0] res0, res1, head;
  logic [GEN_W-1:0] generic_r;
  logic             cfg_wr;
  logic             in_acc;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready &&
                  (paddr[CFG_ADDR_W-1] == REG_GENERIC_VALUE);
  assign prdata = (paddr[CFG_ADDR_W-1] == REG_GENERIC_VALUE) ?
                  CFG_DATA_W'(generic_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      generic_r <= '0;
    end else if (cfg_wr) begin
      generic_r <= pwdata[GEN_W-1:0];
    end
  end

  // The held byte moves on only when the queue can take both of its results.
  assign advance  = stg_valid_r && room2;
  assign in_ready = !stg_valid_r || advance;
  assign in_acc   = in_valid && in_ready;
  assign stg_valid_nxt = in_acc || (stg_valid_r && !advance);
  assign push_cnt = advance ? res_cnt : 2'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_valid_r <= 1'b0;
    end else begin
      stg_valid_r <= stg_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      stg_byte_r <= in_char_byte;
      stg_eoi_r  <= in_end_of_input;
    end
  end

  clt_lexer #(
    .POS_WIDTH (POS_WIDTH),
    .NUM_WIDTH (NUM_WIDTH),
    .RES_W     (RES_W)
  ) u_lexer (
    .clk           (clk),
    .rst_n         (rst_n),
    .step_en       (advance),
    .char_byte     (stg_byte_r),
    .end_of_input  (stg_eoi_r),
    .generic_value (generic_r),
    .res_cnt       (res_cnt),
    .res0          (res0),
    .res1          (res1)
  );

  clt_result_fifo #(
    .WIDTH (RES_W),
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_cnt  (push_cnt),
    .push_d0   (res0),
    .push_d1   (res1),
    .room2     (room2),
    .pop_valid (out_valid),
    .pop_ready (out_ready),
    .pop_d     (head)
  );

  assign {out_kind, out_text_byte, out_number_value, out_start_line,
          out_start_column, out_token_length, out_last} = head;

endmodule

@@ hw/rtl/clt_result_fifo.sv @@
// Small result queue for the tokenizer: up to two entries written per cycle,
// one read per cycle from the head. Depends on nothing.
module clt_result_fifo #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [1:0]       push_cnt,
  input  logic [WIDTH-1:0] push_d0,
  input  logic [WIDTH-1:0] push_d1,
  output logic             room2,
  output logic             pop_valid,
  input  logic             pop_ready,
  output logic [WIDTH-1:0] pop_d
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = PTR_W + 1;

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] head_r, head_nxt;
  logic [PTR_W-1:0] tail_r, tail_nxt;
  logic [PTR_W-1:0] tail_p1;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             pop;

  assign pop       = pop_valid && pop_ready;
  assign pop_valid = (count_r != '0);
  assign pop_d     = mem_r[head_r];
  assign room2     = (count_r <= CNT_W'(DEPTH - 2));
  assign tail_p1   = tail_r + PTR_W'(1);

  always_comb begin
    head_nxt  = pop ? head_r + PTR_W'(1) : head_r;
    tail_nxt  = tail_r + PTR_W'(push_cnt);
    count_nxt = count_r + CNT_W'(push_cnt) - CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      tail_r  <= '0;
      count_r <= '0;
    end else begin
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_cnt != 2'd0) begin
      mem_r[tail_r] <= push_d0;
    end
    if (push_cnt == 2'd2) begin
      mem_r[tail_p1] <= push_d1;
    end
  end

endmodule

@@ hw/rtl/clt_lexer.sv @@
// Lexer state and per-byte step logic: mode, position counters, token
// bookkeeping and the digit accumulator. Uses clt_pkg.
module clt_lexer #(
  parameter int POS_WIDTH = 16,
  parameter int NUM_WIDTH = 31,
  parameter int RES_W     = 12 + NUM_WIDTH + 3 * POS_WIDTH
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     step_en,
  input  logic [7:0]               char_byte,
  input  logic                     end_of_input,
  input  logic [clt_pkg::GEN_W-1:0] generic_value,
  output logic [1:0]               res_cnt,
  output logic [RES_W-1:0]         res0,
  output logic [RES_W-1:0]         res1
);

  import clt_pkg::*;

  typedef logic [POS_WIDTH-1:0] pos_t;
  typedef logic [NUM_WIDTH-1:0] num_t;

  mode_t mode_r, mode_nxt;
  logic  quote_dbl_r, quote_dbl_nxt;
  pos_t  cur_line_r, cur_line_nxt;
  pos_t  cur_col_r, cur_col_nxt;
  pos_t  tok_line_r, tok_line_nxt;
  pos_t  tok_col_r, tok_col_nxt;
  pos_t  tok_len_r, tok_len_nxt;
  num_t  accum_r, accum_nxt;
  logic  all_digits_r, all_digits_nxt;
  logic  starts_star_r, starts_star_nxt;

  // Token base: a fresh token when idle, else the token in progress.
  pos_t  col_v;
  pos_t  base_line, base_col, base_len;
  num_t  base_acc;
  logic  base_alld, base_star;
  logic  is_digit;
  logic [NUM_WIDTH+3:0] acc_ext;
  num_t  acc_add;

  logic  do_body, do_start;
  logic  is_lf, is_cr, blank, quote_hit;

  logic  p_valid, s_valid;
  kind_t p_kind, s_kind, word_kind;
  num_t  p_num, word_num;
  pos_t  p_line, p_col, p_len;
  logic [7:0] p_text;

  function automatic pos_t pos_inc(input pos_t v);
    return (&v) ? v : v + pos_t'(1);
  endfunction

  function automatic logic [RES_W-1:0] pack(input kind_t k, input logic [7:0] t,
                                             input num_t n, input pos_t l,
                                             input pos_t c, input pos_t len,
                                             input logic lst);
    return {k, t, n, l, c, len, lst};
  endfunction

  assign col_v     = pos_inc(cur_col_r);
  assign is_lf     = (char_byte == CH_LF);
  assign is_cr     = (char_byte == CH_CR);
  assign blank     = is_blank(char_byte);
  assign quote_hit = (char_byte == (quote_dbl_r ? CH_DQUOTE : CH_SQUOTE));
  assign is_digit  = (char_byte inside {[CH_ZERO:CH_NINE]});

  always_comb begin
    if (mode_r == MODE_IDLE) begin
      base_line = cur_line_r;
      base_col  = col_v;
      base_len  = '0;
      base_acc  = '0;
      base_alld = 1'b1;
      base_star = (char_byte == CH_STAR);
    end else begin
      base_line = tok_line_r;
      base_col  = tok_col_r;
      base_len  = tok_len_r;
      base_acc  = accum_r;
      base_alld = all_digits_r;
      base_star = starts_star_r;
    end
  end

  // Multiply by ten as two shifts and an add, add the digit, then saturate.
  always_comb begin
    acc_ext = ({4'b0000, base_acc} << 3) + ({4'b0000, base_acc} << 1) +
              (NUM_WIDTH + 4)'(char_byte[3:0]);
    acc_add = (|acc_ext[NUM_WIDTH+3:NUM_WIDTH]) ? '1 : acc_ext[NUM_WIDTH-1:0];
  end

  always_comb begin
    if (starts_star_r && (tok_len_r == pos_t'(1))) begin
      word_kind = KIND_GENERIC;
      word_num  = num_t'(generic_value);
    end else if (all_digits_r && !starts_star_r) begin
      word_kind = KIND_NUMBER;
      word_num  = accum_r;
    end else begin
      word_kind = KIND_WORD;
      word_num  = '0;
    end
  end

  always_comb begin
    mode_nxt        = mode_r;
    quote_dbl_nxt   = quote_dbl_r;
    cur_line_nxt    = cur_line_r;
    cur_col_nxt     = cur_col_r;
    tok_line_nxt    = tok_line_r;
    tok_col_nxt     = tok_col_r;
    tok_len_nxt     = tok_len_r;
    accum_nxt       = accum_r;
    all_digits_nxt  = all_digits_r;
    starts_star_nxt = starts_star_r;
    do_body  = 1'b0;
    do_start = 1'b0;
    p_valid  = 1'b0;
    p_kind   = KIND_BYTE;
    p_text   = '0;
    p_num    = '0;
    p_line   = tok_line_r;
    p_col    = tok_col_r;
    p_len    = tok_len_r;
    s_valid  = 1'b0;
    s_kind   = KIND_NEWLINE;

    if (end_of_input) begin
      s_valid = 1'b1;
      s_kind  = KIND_END;
      case (mode_r)
        MODE_WORD: begin
          p_valid = 1'b1;
          p_kind  = word_kind;
          p_num   = word_num;
        end
        MODE_QUOTE: begin
          p_valid = 1'b1;
          p_kind  = KIND_BADQUOTE;
        end
        MODE_COMMENT: begin
          p_valid = 1'b1;
          p_kind  = KIND_COMMENT;
        end
        default: begin
        end
      endcase
      mode_nxt     = MODE_IDLE;
      cur_line_nxt = pos_t'(1);
      cur_col_nxt  = '0;
    end else begin
      if (is_lf) begin
        cur_line_nxt = pos_inc(cur_line_r);
        cur_col_nxt  = '0;
      end else if (!is_cr) begin
        cur_col_nxt = col_v;
      end
      // Every newline byte ends in idle mode and reports its own result.
      s_valid = is_lf;

      case (mode_r)
        MODE_WORD: begin
          if (is_lf || blank) begin
            p_valid  = 1'b1;
            p_kind   = word_kind;
            p_num    = word_num;
            mode_nxt = MODE_IDLE;
          end else begin
            do_body = 1'b1;
          end
        end
        MODE_QUOTE: begin
          if (quote_hit) begin
            p_valid  = 1'b1;
            p_kind   = KIND_WORD;
            mode_nxt = MODE_IDLE;
          end else if (is_lf || is_cr) begin
            p_valid  = 1'b1;
            p_kind   = KIND_BADQUOTE;
            mode_nxt = MODE_IDLE;
          end else begin
            do_body = 1'b1;
          end
        end
        MODE_COMMENT: begin
          if (is_lf) begin
            p_valid  = 1'b1;
            p_kind   = KIND_COMMENT;
            mode_nxt = MODE_IDLE;
          end else begin
            do_body = 1'b1;
          end
        end
        default: begin
          if (char_byte == CH_HASH) begin
            do_start = 1'b1;
            mode_nxt = MODE_COMMENT;
          end else if ((char_byte == CH_SQUOTE) || (char_byte == CH_DQUOTE)) begin
            do_start      = 1'b1;
            quote_dbl_nxt = (char_byte == CH_DQUOTE);
            mode_nxt      = MODE_QUOTE;
          end else if (!is_lf && !blank) begin
            do_body  = 1'b1;
            mode_nxt = MODE_WORD;
          end
        end
      endcase

      if (do_start) begin
        tok_line_nxt    = base_line;
        tok_col_nxt     = base_col;
        tok_len_nxt     = '0;
        accum_nxt       = '0;
        all_digits_nxt  = 1'b1;
        starts_star_nxt = 1'b0;
      end
      if (do_body) begin
        tok_line_nxt    = base_line;
        tok_col_nxt     = base_col;
        tok_len_nxt     = pos_inc(base_len);
        accum_nxt       = is_digit ? acc_add : base_acc;
        all_digits_nxt  = base_alld && is_digit;
        starts_star_nxt = base_star;
        p_valid         = 1'b1;
        p_kind          = KIND_BYTE;
        p_text          = char_byte;
        p_line          = base_line;
        p_col           = base_col;
        p_len           = '0;
      end
    end
  end

  always_comb begin
    res_cnt = {1'b0, p_valid} + {1'b0, s_valid};
    res1    = pack(s_kind, 8'h00, '0, cur_line_r, col_v, '0, 1'b1);
    if (p_valid) begin
      res0 = pack(p_kind, p_text, p_num, p_line, p_col, p_len, !s_valid);
    end else begin
      res0 = res1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r        <= MODE_IDLE;
      quote_dbl_r   <= 1'b0;
      cur_line_r    <= pos_t'(1);
      cur_col_r     <= '0;
      tok_line_r    <= pos_t'(1);
      tok_col_r     <= pos_t'(1);
      tok_len_r     <= '0;
      accum_r       <= '0;
      all_digits_r  <= 1'b1;
      starts_star_r <= 1'b0;
    end else if (step_en) begin
      mode_r        <= mode_nxt;
      quote_dbl_r   <= quote_dbl_nxt;
      cur_line_r    <= cur_line_nxt;
      cur_col_r     <= cur_col_nxt;
      tok_line_r    <= tok_line_nxt;
      tok_col_r     <= tok_col_nxt;
      tok_len_r     <= tok_len_nxt;
      accum_r       <= accum_nxt;
      all_digits_r  <= all_digits_nxt;
      starts_star_r <= starts_star_nxt;
    end
  end

endmodule

@@ tb/config_line_tokenizer_tb.sv @@
// Self-checking testbench for config_line_tokenizer: random and directed text streams,
// a token predictor kept in step with every accepted transaction, APB register writes
// and readbacks. Depends on clt_pkg and the config_line_tokenizer RTL.
module config_line_tokenizer_tb;
  import clt_pkg::*;

  localparam int POS_W = 16;
  localparam int NUM_W = 31;
  localparam logic [POS_W-1:0] POS_MAX = '1;
  localparam logic [NUM_W-1:0] NUM_MAX = '1;
  localparam int STALL_LIMIT = 3000;
  localparam int HOLD_CYCLES = 400;
  localparam int HOLD_AFTER  = 150;
  localparam int MAX_SHOWN   = 10;
  localparam logic [CFG_ADDR_W-1:0] ADDR_GENERIC_VALUE = {REG_GENERIC_VALUE, 2'b00};

  typedef struct {
    logic [7:0] ch;
    logic       eoi;
  } char_item_t;

  typedef struct {
    kind_t            kind;
    logic [7:0]       text;
    logic [NUM_W-1:0] num;
    logic [POS_W-1:0] line;
    logic [POS_W-1:0] col;
    logic [POS_W-1:0] len;
    logic             last;
  } token_res_t;

  typedef enum {
    BYTES_WORD_START, BYTES_WORD, BYTES_SQUOTE, BYTES_DQUOTE, BYTES_COMMENT
  } byte_class_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [7:0]            in_char_byte = '0;
  logic                  in_end_of_input = 1'b0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [2:0]            out_kind;
  logic [7:0]            out_text_byte;
  logic [NUM_W-1:0]      out_number_value;
  logic [POS_W-1:0]      out_start_line;
  logic [POS_W-1:0]      out_start_column;
  logic [POS_W-1:0]      out_token_length;
  logic                  out_last;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr = '0;
  logic [CFG_DATA_W-1:0] pwdata = '0;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  // Predictor state.
  mode_t            lx_mode;
  logic             lx_dquote;
  logic [POS_W-1:0] lx_line, lx_col, lx_tok_line, lx_tok_col, lx_tok_len;
  logic [NUM_W-1:0] lx_accum;
  logic             lx_digits, lx_star;
  logic [GEN_W-1:0] generic_val;
  token_res_t       step_res[2];
  int               step_n;

  token_res_t tokens_due[$];
  char_item_t chars_pending[$];
  int         chars_made = 0;
  int         fault_count = 0;
  int         results_seen = 0;
  int         quiet_cycles = 0;
  int         tx_gap = 0;
  int         rx_gap = 0;
  int         rx_hold = 0;
  bit         held = 1'b0;
  bit         tx_idle_en = 1'b1;
  bit         rx_idle_en = 1'b1;

  config_line_tokenizer dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_char_byte     (in_char_byte),
    .in_end_of_input  (in_end_of_input),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_kind         (out_kind),
    .out_text_byte    (out_text_byte),
    .out_number_value (out_number_value),
    .out_start_line   (out_start_line),
    .out_start_column (out_start_column),
    .out_token_length (out_token_length),
    .out_last         (out_last),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  always #1 clk = ~clk;

  function automatic logic [POS_W-1:0] pos_inc(input logic [POS_W-1:0] v);
    return (v == POS_MAX) ? v : v + POS_W'(1);
  endfunction

  function automatic bit is_ws(input logic [7:0] c);
    return c == CH_SPACE || c == CH_TAB || c == CH_CR || c == CH_VT || c == CH_FF;
  endfunction

  function automatic void emit(input kind_t kind, input logic [7:0] text,
                               input logic [NUM_W-1:0] num, input logic [POS_W-1:0] line,
                               input logic [POS_W-1:0] col, input logic [POS_W-1:0] len);
    step_res[step_n] = '{kind, text, num, line, col, len, 1'b0};
    step_n++;
  endfunction

  function automatic void open_token(input logic [POS_W-1:0] line,
                                     input logic [POS_W-1:0] col);
    lx_tok_line = line;
    lx_tok_col  = col;
    lx_tok_len  = '0;
    lx_accum    = '0;
    lx_digits   = 1'b1;
    lx_star     = 1'b0;
  endfunction

  function automatic void add_body(input logic [7:0] c);
    longint unsigned acc;
    lx_tok_len = pos_inc(lx_tok_len);
    if (c >= CH_ZERO && c <= CH_NINE) begin
      acc = longint'(lx_accum) * 10 + longint'(c - CH_ZERO);
      lx_accum = (acc > longint'(NUM_MAX)) ? NUM_MAX : acc[NUM_W-1:0];
    end else begin
      lx_digits = 1'b0;
    end
    emit(KIND_BYTE, c, '0, lx_tok_line, lx_tok_col, '0);
  endfunction

  function automatic void close_word();
    if (lx_star && lx_tok_len == POS_W'(1))
      emit(KIND_GENERIC, '0, NUM_W'(generic_val), lx_tok_line, lx_tok_col, lx_tok_len);
    else if (lx_digits && !lx_star)
      emit(KIND_NUMBER, '0, lx_accum, lx_tok_line, lx_tok_col, lx_tok_len);
    else
      emit(KIND_WORD, '0, '0, lx_tok_line, lx_tok_col, lx_tok_len);
  endfunction

  function automatic void reset_lexer();
    lx_mode     = MODE_IDLE;
    lx_dquote   = 1'b0;
    lx_line     = POS_W'(1);
    lx_col      = '0;
    generic_val = '0;
    open_token(POS_W'(1), POS_W'(1));
  endfunction

  // Works out the results of one accepted input transaction.
  function automatic void predict_tokens(input logic [7:0] c, input logic eoi);
    logic [POS_W-1:0] line_now;
    logic [POS_W-1:0] col_now;
    bit               nl;
    step_n   = 0;
    line_now = lx_line;
    col_now  = pos_inc(lx_col);
    if (eoi) begin
      case (lx_mode)
        MODE_WORD:    close_word();
        MODE_QUOTE:   emit(KIND_BADQUOTE, '0, '0, lx_tok_line, lx_tok_col, lx_tok_len);
        MODE_COMMENT: emit(KIND_COMMENT, '0, '0, lx_tok_line, lx_tok_col, lx_tok_len);
        default: ;
      endcase
      emit(KIND_END, '0, '0, line_now, col_now, '0);
      lx_mode = MODE_IDLE;
      lx_line = POS_W'(1);
      lx_col  = '0;
    end else begin
      nl = (c == CH_LF);
      if (nl) begin
        lx_line = pos_inc(lx_line);
        lx_col  = '0;
      end else if (c != CH_CR) begin
        lx_col = col_now;
      end
      case (lx_mode)
        MODE_WORD: begin
          if (nl || is_ws(c)) begin
            close_word();
            lx_mode = MODE_IDLE;
          end else begin
            add_body(c);
          end
        end
        MODE_QUOTE: begin
          if (c == (lx_dquote ? CH_DQUOTE : CH_SQUOTE)) begin
            emit(KIND_WORD, '0, '0, lx_tok_line, lx_tok_col, lx_tok_len);
            lx_mode = MODE_IDLE;
          end else if (nl || c == CH_CR) begin
            emit(KIND_BADQUOTE, '0, '0, lx_tok_line, lx_tok_col, lx_tok_len);
            lx_mode = MODE_IDLE;
          end else begin
            add_body(c);
          end
        end
        MODE_COMMENT: begin
          if (nl) begin
            emit(KIND_COMMENT, '0, '0, lx_tok_line, lx_tok_col, lx_tok_len);
            lx_mode = MODE_IDLE;
          end else begin
            add_body(c);
          end
        end
        default: begin
          if (c == CH_HASH) begin
            open_token(line_now, col_now);
            lx_mode = MODE_COMMENT;
          end else if (c == CH_SQUOTE || c == CH_DQUOTE) begin
            open_token(line_now, col_now);
            lx_dquote = (c == CH_DQUOTE);
            lx_mode   = MODE_QUOTE;
          end else if (!nl && !is_ws(c)) begin
            open_token(line_now, col_now);
            lx_star = (c == CH_STAR);
            lx_mode = MODE_WORD;
            add_body(c);
          end
        end
      endcase
      if (nl && lx_mode == MODE_IDLE)
        emit(KIND_NEWLINE, '0, '0, line_now, col_now, '0);
    end
    if (step_n > 0)
      step_res[step_n-1].last = 1'b1;
    for (int i = 0; i < step_n; i++)
      tokens_due.push_back(step_res[i]);
  endfunction

  function automatic int pick_gap(input bit en);
    int r;
    r = $urandom_range(0, 99);
    if (!en || r < 55)
      return 0;
    else if (r < 85)
      return $urandom_range(1, 3);
    else if (r < 97)
      return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic void note_fault(input string msg);
    fault_count++;
    if (fault_count <= MAX_SHOWN)
      $display("%s", msg);
  endfunction

  function automatic void push_byte(input logic [7:0] c);
    chars_pending.push_back('{c, 1'b0});
    chars_made++;
  endfunction

  function automatic void push_end(input logic [7:0] c);
    chars_pending.push_back('{c, 1'b1});
    chars_made++;
  endfunction

  function automatic void push_text(input string s);
    for (int i = 0; i < s.len(); i++)
      push_byte(s[i]);
  endfunction

  function automatic logic [7:0] pick_blank();
    case ($urandom_range(0, 4))
      0:       return CH_SPACE;
      1:       return CH_TAB;
      2:       return CH_CR;
      3:       return CH_VT;
      default: return CH_FF;
    endcase
  endfunction

  function automatic logic [7:0] rand_byte(input byte_class_t cls);
    logic [7:0] c;
    bit         ok;
    ok = 1'b0;
    c  = '0;
    while (!ok) begin
      c = ($urandom_range(0, 3) != 0) ? 8'($urandom_range(8'h21, 8'h7E))
                                      : 8'($urandom_range(0, 255));
      case (cls)
        BYTES_WORD_START: ok = !is_ws(c) && c != CH_LF && c != CH_HASH &&
                               c != CH_SQUOTE && c != CH_DQUOTE;
        BYTES_WORD:       ok = !is_ws(c) && c != CH_LF;
        BYTES_SQUOTE:     ok = c != CH_SQUOTE && c != CH_LF && c != CH_CR;
        BYTES_DQUOTE:     ok = c != CH_DQUOTE && c != CH_LF && c != CH_CR;
        default:          ok = c != CH_LF;
      endcase
    end
    return c;
  endfunction

  // Mostly well-formed tokens with random content, with some noise and broken quotes.
  function automatic void gen_random_items(input int count);
    int          target;
    int          r;
    int          len;
    logic [7:0]  q;
    target = chars_made + count;
    while (chars_made < target) begin
      r = $urandom_range(0, 99);
      if (r < 30) begin
        push_byte(rand_byte(BYTES_WORD_START));
        len = $urandom_range(0, 5);
        repeat (len) push_byte(rand_byte(BYTES_WORD));
      end else if (r < 45) begin
        len = ($urandom_range(0, 6) == 0) ? $urandom_range(9, 12) : $urandom_range(1, 4);
        repeat (len) push_byte(CH_ZERO + 8'($urandom_range(0, 9)));
      end else if (r < 52) begin
        push_byte(CH_STAR);
      end else if (r < 56) begin
        push_byte(CH_STAR);
        len = $urandom_range(1, 3);
        repeat (len) push_byte($urandom_range(0, 1) ? CH_ZERO + 8'($urandom_range(0, 9))
                                                    : rand_byte(BYTES_WORD));
      end else if (r < 70) begin
        q = $urandom_range(0, 1) ? CH_DQUOTE : CH_SQUOTE;
        push_byte(q);
        len = $urandom_range(0, 5);
        repeat (len) push_byte(rand_byte(q == CH_DQUOTE ? BYTES_DQUOTE : BYTES_SQUOTE));
        case ($urandom_range(0, 19))
          0:       push_byte(CH_LF);
          1:       push_byte(CH_CR);
          2:       push_end(8'($urandom_range(0, 255)));
          default: push_byte(q);
        endcase
      end else if (r < 80) begin
        push_byte(CH_HASH);
        len = $urandom_range(0, 8);
        repeat (len) push_byte(rand_byte(BYTES_COMMENT));
        if ($urandom_range(0, 9) == 0)
          push_end(8'($urandom_range(0, 255)));
        else
          push_byte(CH_LF);
      end else if (r < 85) begin
        push_byte(8'($urandom_range(0, 255)));
      end else if (r < 88) begin
        push_end(8'($urandom_range(0, 255)));
      end else begin
        push_byte(CH_LF);
      end
      case ($urandom_range(0, 9))
        0, 1, 2, 3: push_byte(pick_blank());
        4, 5: begin
          push_byte(pick_blank());
          push_byte(pick_blank());
        end
        6, 7:    push_byte(CH_LF);
        8:       ;
        default: push_end(8'($urandom_range(0, 255)));
      endcase
    end
  endfunction

  // Input side: one transaction at a time from the pending queue.
  always @(posedge clk) begin : feed
    char_item_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
      tx_gap = 0;
    end else begin
      if (in_valid && in_ready)
        predict_tokens(in_char_byte, in_end_of_input);
      if (!in_valid || in_ready) begin
        if (tx_gap > 0) begin
          tx_gap--;
          in_valid <= 1'b0;
        end else if (chars_pending.size() > 0) begin
          nxt = chars_pending.pop_front();
          in_char_byte    <= nxt.ch;
          in_end_of_input <= nxt.eoi;
          in_valid        <= 1'b1;
          tx_gap = pick_gap(tx_idle_en);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Output side: checks each result transaction and paces out_ready.
  always @(posedge clk) begin : collect
    token_res_t exp;
    if (!rst_n) begin
      out_ready <= 1'b0;
      rx_gap = 0;
    end else begin
      if (out_valid && out_ready) begin
        results_seen++;
        if (tokens_due.size() == 0) begin
          note_fault($sformatf("unexpected result: kind=%0d byte=%02h num=%0d pos=%0d:%0d len=%0d",
                               out_kind, out_text_byte, out_number_value, out_start_line,
                               out_start_column, out_token_length));
        end else begin
          exp = tokens_due.pop_front();
          if (exp.kind !== out_kind || exp.text !== out_text_byte ||
              exp.num !== out_number_value || exp.line !== out_start_line ||
              exp.col !== out_start_column || exp.len !== out_token_length ||
              exp.last !== out_last)
            note_fault($sformatf({"result mismatch: exp kind=%0d byte=%02h num=%0d pos=%0d:%0d",
                                  " len=%0d last=%0b / got kind=%0d byte=%02h num=%0d",
                                  " pos=%0d:%0d len=%0d last=%0b"},
                                 exp.kind, exp.text, exp.num, exp.line, exp.col, exp.len,
                                 exp.last, out_kind, out_text_byte, out_number_value,
                                 out_start_line, out_start_column, out_token_length, out_last));
        end
      end
      // One long hold-off lets the result queue fill so the input side must stall.
      if (!held && results_seen >= HOLD_AFTER) begin
        held = 1'b1;
        rx_hold = HOLD_CYCLES;
      end
      if (rx_hold > 0) begin
        rx_hold--;
        out_ready <= 1'b0;
      end else if (rx_gap > 0) begin
        rx_gap--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        rx_gap = pick_gap(rx_idle_en);
      end
    end
  end

  always @(posedge clk) begin : watchdog
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  task automatic drain();
    while (chars_pending.size() != 0 || in_valid || tokens_due.size() != 0)
      @(posedge clk);
    // A final byte may produce no result yet still be in flight.
    repeat (8) @(posedge clk);
  endtask

  task automatic set_generic(input logic [GEN_W-1:0] v);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_GENERIC_VALUE;
    pwdata  <= CFG_DATA_W'(v);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    generic_val = v;
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata[GEN_W-1:0] !== v)
      note_fault($sformatf("generic_value readback: exp %02h got %08h", v, prdata));
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  initial begin
    reset_lexer();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    set_generic('0);
    push_text("* 42\n");
    push_byte(8'hFF);
    push_byte(8'h00);
    push_byte(CH_VT);
    push_text("\"x\"");
    push_byte(CH_SQUOTE);
    push_byte(CH_CR);
    push_text("#c");
    push_byte(CH_FF);
    push_byte(CH_LF);
    push_text("*7");
    push_byte(CH_CR);
    push_text("12");
    push_end(8'h5A);
    push_text("'q");
    push_end(8'hFF);
    drain();

    set_generic('1);
    push_text("*\n");
    gen_random_items(100);
    drain();

    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    set_generic(GEN_W'($urandom_range(1, 254)));
    gen_random_items(100);
    drain();

    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
    set_generic(GEN_W'($urandom_range(0, 255)));
    gen_random_items(100);
    drain();

    set_generic(GEN_W'($urandom_range(0, 255)));
    gen_random_items(100);
    drain();

    repeat (20) @(posedge clk);
    if (fault_count == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule

@@ config_line_tokenizer.f @@
hw/rtl/clt_pkg.sv
hw/rtl/clt_result_fifo.sv
hw/rtl/clt_lexer.sv
hw/rtl/config_line_tokenizer.sv
tb/config_line_tokenizer_tb.sv
